>>> rtl/core/pdws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdws_pkg
// shared types and constants of the pulse detector with window statistics
// ----------------------------------------------------------------------------
package pdws_pkg;

  localparam int SampleBits = 12;
  localparam int CountBits  = 32;
  localparam int LevelBits  = 13;
  localparam int SumBits    = 45;
  localparam int StampBits  = 32;
  localparam int QuotBits   = SumBits;

  localparam logic signed [LevelBits-1:0] LevelMax = 13'sd4095;
  localparam logic signed [LevelBits-1:0] LevelMin = -13'sd4095;
  localparam logic [CountBits-1:0] CountLimit = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    OpSample     = 2'd0,
    OpReadWindow = 2'd1,
    OpReadPulse  = 2'd2,
    OpUnused     = 2'd3
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input word
    logic sample;     // apply the sample update
    logic div_start;  // start division
    logic div_sel;    // 0 window average, 1 run average
    logic save;       // commit finished run to held pulse
    logic rd_window;  // latch window result and clear
    logic rd_pulse;   // latch pulse result and clear
    logic status;     // latch status fields
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic pulse_end;  // current sample closes a pulse
    logic save_ok;    // finished run replaces held pulse
    op_e  op;
  } stat_t;

endpackage

>>> rtl/core/pdws_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdws_div
// restoring signed divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module pdws_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [pdws_pkg::SumBits-1:0]     dividend_i,
  input  logic        [pdws_pkg::CountBits-1:0]   divisor_i,
  output logic                                    done_o,
  output logic signed [pdws_pkg::LevelBits-1:0]   quot_o
);

  localparam int QB = pdws_pkg::QuotBits;
  localparam int CB = pdws_pkg::CountBits;
  localparam int IB = $clog2(QB + 1);

  logic          busy_q, busy_d;
  logic [IB-1:0] cnt_q, cnt_d;
  logic [QB-1:0] quo_q, quo_d;
  logic [CB:0]   rem_q, rem_d;
  logic [CB-1:0] dvs_q, dvs_d;
  logic          neg_q, neg_d;
  logic          done_q, done_d;
  logic [CB:0]   shifted;
  logic [QB-1:0] mag;
  logic [QB-1:0] res;

  assign mag     = dividend_i[QB-1] ? QB'(-dividend_i) : QB'(dividend_i);
  assign shifted = {rem_q[CB-1:0], quo_q[QB-1]};
  assign res     = neg_q ? QB'(-quo_q) : quo_q;
  assign quot_o  = res[pdws_pkg::LevelBits-1:0];
  assign done_o  = done_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = IB'(QB);
      quo_d  = mag;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[QB-1];
      if (divisor_i == '0) begin
        busy_d = 1'b0;
        quo_d  = '0;
        done_d = 1'b1;
      end
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        quo_d = {quo_q[QB-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[QB-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == IB'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

endmodule

>>> rtl/core/pdws_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdws_datapath
// window and pulse state, trigger register and result word
// ----------------------------------------------------------------------------
module pdws_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pdws_pkg::cmd_t                         cmd_i,
  output pdws_pkg::stat_t                        stat_o,
  input  logic [1:0]                             opcode_i,
  input  logic [pdws_pkg::SampleBits-1:0]        sample_i,
  input  logic [pdws_pkg::SampleBits-1:0]        offset_i,
  input  logic [pdws_pkg::StampBits-1:0]         stamp_i,
  input  logic                                   trig_we_i,
  input  logic [pdws_pkg::LevelBits-1:0]         trig_i,
  output logic [pdws_pkg::LevelBits-1:0]         trig_o,
  output logic [225:0]                           result_o
);

  localparam int LB = pdws_pkg::LevelBits;
  localparam int SB = pdws_pkg::SumBits;
  localparam int CB = pdws_pkg::CountBits;
  localparam int TB = pdws_pkg::StampBits;

  logic signed [LB-1:0] trig_q;
  logic [1:0]           op_q;
  logic signed [LB-1:0] sig_q;
  logic [TB-1:0]        ts_q;

  logic signed [SB-1:0] wsum_q;
  logic [CB-1:0]        wcnt_q;
  logic signed [LB-1:0] wlow_q, whigh_q;
  logic                 inp_q;
  logic signed [SB-1:0] rsum_q;
  logic [CB-1:0]        rcnt_q;
  logic signed [LB-1:0] rpeak_q;
  logic [TB-1:0]        rstart_q;
  logic [TB-1:0]        hstart_q, hlen_q, hnum_q;
  logic signed [LB-1:0] hpeak_q, hmean_q;
  logic [TB-1:0]        pcnt_q, lsaved_q;

  logic signed [LB-1:0] r_wmin_q, r_wave_q, r_wmax_q, r_ppeak_q, r_pmean_q;
  logic [TB-1:0]        r_pstart_q, r_plen_q, r_pnum_q, r_next_q, r_last_q;
  logic                 r_in_q;

  logic signed [LB:0]   diff;
  logic signed [LB-1:0] sig;
  logic                 div_done;
  logic signed [LB-1:0] quot;
  logic signed [SB-1:0] div_a;
  logic [CB-1:0]        div_b;
  logic                 rec;

  assign diff = $signed({2'b00, sample_i}) - $signed({2'b00, offset_i});
  always_comb begin
    if (diff > $signed({pdws_pkg::LevelMax[LB-1], pdws_pkg::LevelMax})) begin
      sig = pdws_pkg::LevelMax;
    end else if (diff < $signed({pdws_pkg::LevelMin[LB-1], pdws_pkg::LevelMin})) begin
      sig = pdws_pkg::LevelMin;
    end else begin
      sig = diff[LB-1:0];
    end
  end

  assign div_a = cmd_i.div_sel ? rsum_q : wsum_q;
  assign div_b = cmd_i.div_sel ? rcnt_q : wcnt_q;

  pdws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // run is recorded when a pulse opens, continues or closes
  assign rec = inp_q || (sig_q >= trig_q);

  assign stat_o.div_done  = div_done;
  assign stat_o.pulse_end = inp_q && (sig_q < trig_q);
  assign stat_o.save_ok   = hlen_q <= rcnt_q;
  assign stat_o.op        = pdws_pkg::op_e'(op_q);
  assign trig_o           = trig_q;

  assign result_o = {r_in_q, r_last_q, r_next_q, r_pnum_q, r_pmean_q, r_ppeak_q,
                     r_plen_q, r_pstart_q, r_wmax_q, r_wave_q, r_wmin_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q   <= '0;
      wsum_q   <= '0;
      wcnt_q   <= '0;
      wlow_q   <= pdws_pkg::LevelMax;
      whigh_q  <= pdws_pkg::LevelMin;
      inp_q    <= 1'b0;
      rsum_q   <= '0;
      rcnt_q   <= '0;
      rpeak_q  <= '0;
      rstart_q <= '0;
      hstart_q <= '0;
      hlen_q   <= '0;
      hpeak_q  <= '0;
      hmean_q  <= '0;
      hnum_q   <= '0;
      pcnt_q   <= TB'(1);
      lsaved_q <= '0;
    end else begin
      if (trig_we_i) begin
        trig_q <= trig_i;
      end
      if (cmd_i.sample) begin
        if (wcnt_q != pdws_pkg::CountLimit) begin
          wsum_q <= wsum_q + SB'(sig_q);
          wcnt_q <= wcnt_q + 1'b1;
        end
        if (sig_q < wlow_q) begin
          wlow_q <= sig_q;
        end
        if (sig_q > whigh_q) begin
          whigh_q <= sig_q;
        end
        if (!inp_q && sig_q >= trig_q) begin
          inp_q    <= 1'b1;
          rstart_q <= ts_q;
        end
        if (rec) begin
          if (rcnt_q != pdws_pkg::CountLimit) begin
            rsum_q <= rsum_q + SB'(sig_q);
            rcnt_q <= rcnt_q + 1'b1;
          end
          if (sig_q > rpeak_q) begin
            rpeak_q <= sig_q;
          end
        end
      end
      if (cmd_i.save) begin
        if (hlen_q <= rcnt_q) begin
          lsaved_q <= pcnt_q - 1'b1;
          hnum_q   <= pcnt_q;
          pcnt_q   <= pcnt_q + 1'b1;
          hstart_q <= rstart_q;
          hlen_q   <= rcnt_q;
          hpeak_q  <= rpeak_q;
          hmean_q  <= quot;
        end
        rsum_q   <= '0;
        rcnt_q   <= '0;
        rpeak_q  <= '0;
        rstart_q <= '0;
        inp_q    <= 1'b0;
      end
      if (cmd_i.rd_window) begin
        wsum_q  <= '0;
        wcnt_q  <= '0;
        wlow_q  <= pdws_pkg::LevelMax;
        whigh_q <= pdws_pkg::LevelMin;
      end
      if (cmd_i.rd_pulse) begin
        hstart_q <= '0;
        hlen_q   <= '0;
        hpeak_q  <= '0;
        hmean_q  <= '0;
        hnum_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      sig_q <= sig;
      ts_q  <= stamp_i;
      r_wmin_q   <= '0;
      r_wave_q   <= '0;
      r_wmax_q   <= '0;
      r_pstart_q <= '0;
      r_plen_q   <= '0;
      r_ppeak_q  <= '0;
      r_pmean_q  <= '0;
      r_pnum_q   <= '0;
    end
    if (cmd_i.rd_window) begin
      r_wmin_q <= wlow_q;
      r_wave_q <= quot;
      r_wmax_q <= whigh_q;
    end
    if (cmd_i.rd_pulse) begin
      r_pstart_q <= hstart_q;
      r_plen_q   <= hlen_q;
      r_ppeak_q  <= hpeak_q;
      r_pmean_q  <= hmean_q;
      r_pnum_q   <= hnum_q;
    end
    if (cmd_i.status) begin
      r_next_q <= pcnt_q;
      r_last_q <= lsaved_q;
      r_in_q   <= inp_q;
    end
  end

endmodule

>>> rtl/core/pdws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdws_ctrl
// sequencer for one word: update, divide, commit, present result
// ----------------------------------------------------------------------------
module pdws_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pdws_pkg::stat_t stat_i,
  output pdws_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StDecode = 7'b0000010,
    StWinDiv = 7'b0000100,
    StRunChk = 7'b0001000,
    StRunDiv = 7'b0010000,
    StStatus = 7'b0100000,
    StOut    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = state_q == StOut;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        unique case (stat_i.op)
          pdws_pkg::OpSample: begin
            cmd_o.sample = 1'b1;
            state_d      = StRunChk;
            if (!stat_i.pulse_end) begin
              state_d = StStatus;
            end
          end
          pdws_pkg::OpReadWindow: begin
            cmd_o.div_start = 1'b1;
            state_d         = StWinDiv;
          end
          pdws_pkg::OpReadPulse: begin
            cmd_o.rd_pulse = 1'b1;
            state_d        = StStatus;
          end
          default: state_d = StStatus;
        endcase
      end
      StWinDiv: begin
        if (stat_i.div_done) begin
          cmd_o.rd_window = 1'b1;
          state_d         = StStatus;
        end
      end
      StRunChk: begin
        if (stat_i.save_ok) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = StRunDiv;
        end else begin
          cmd_o.save = 1'b1;
          state_d    = StStatus;
        end
      end
      StRunDiv: begin
        cmd_o.div_sel = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.save = 1'b1;
          state_d    = StStatus;
        end
      end
      StStatus: begin
        cmd_o.status = 1'b1;
        state_d      = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/pulse_detector_with_window_stats_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_detector_with_window_stats_core
// pulse detector with window min, max and average
// ----------------------------------------------------------------------------
// One word at a time. A sample word passes decode and status; one that ends
// a pulse also passes the run check and, when the run replaces the held one,
// waits for the divider as well; a window read waits for the divider; a pulse read does not.
// The long cases come from the bit-serial divider that forms averages, one
// quotient bit per cycle over the 45-bit sum. The result is held in the
// output register until taken.
module pulse_detector_with_window_stats_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // sample_level[11:0], offset_level[23:12], timestamp[55:24]
  input  logic [55:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // window_min, window_ave, window_max, pulse_start_time, pulse_length,
  // pulse_peak, pulse_mean, pulse_number, next_pulse_number,
  // last_saved_number, inside_pulse[225], zero fill to 232
  output logic [231:0] m_axis_tdata_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  pdws_pkg::cmd_t  cmd;
  pdws_pkg::stat_t stat;
  logic [pdws_pkg::LevelBits-1:0] trig;
  logic [225:0] result;
  logic         trig_we;

  assign pready  = 1'b1;
  assign trig_we = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata  = (paddr == 2'd0) ? {{19{trig[12]}}, trig} : 32'd0;
  assign m_axis_tdata_o = {6'b000000, result};

  pdws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pdws_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .opcode_i  (s_axis_tuser_i),
    .sample_i  (s_axis_tdata_i[11:0]),
    .offset_i  (s_axis_tdata_i[23:12]),
    .stamp_i   (s_axis_tdata_i[55:24]),
    .trig_we_i (trig_we),
    .trig_i    (pwdata[12:0]),
    .trig_o    (trig),
    .result_o  (result)
  );

endmodule

>>> rtl/core/pdws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdws_checker
// port-level checks of the pulse detector
// ----------------------------------------------------------------------------
module pdws_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [231:0] m_axis_tdata_o
);

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o)) else $error("busy overlap");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o) else $error("accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("out hold");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[231:226] == 6'b000000) else $error("fill");

endmodule

bind pulse_detector_with_window_stats_core pdws_checker u_pdws_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

>>> verif/pulse_detector_with_window_stats_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_detector_with_window_stats_core_test
// self-checking bench: pulse runs, window and pulse reads over several
// trigger levels, with random stalls on both stream sides
// ----------------------------------------------------------------------------
module pulse_detector_with_window_stats_core_test;

  typedef struct {
    logic signed [12:0] wmin, wave, wmax;
    logic [31:0] pstart, plen;
    logic signed [12:0] ppeak, pmean;
    logic [31:0] pnum, nextnum, lastnum;
    logic in_pulse;
  } stats_word_t;

  class pulse_scoreboard;
    logic signed [12:0] trig;
    longint wsum, rsum;
    longint unsigned wcnt, rcnt;
    int wlow, whigh, rpeak, hpeak, hmean;
    bit inp;
    bit [31:0] rstart, hstart, hlen, hnum, pcnt, lsaved;
    stats_word_t pending[$];
    int errors, words_seen;

    function void clear_all();
      trig = 0; wsum = 0; wcnt = 0; wlow = 4095; whigh = -4095;
      inp = 0; rsum = 0; rcnt = 0; rpeak = 0; rstart = 0;
      hstart = 0; hlen = 0; hpeak = 0; hmean = 0; hnum = 0;
      pcnt = 1; lsaved = 0; errors = 0; words_seen = 0;
    endfunction

    function void add_to_run(int sig);
      if (rcnt < 64'hFFFF_FFFF) begin
        rsum += sig;
        rcnt++;
      end
      if (sig > rpeak) rpeak = sig;
    endfunction

    function void note_word(pdws_pkg::op_e op, logic [11:0] smp, logic [11:0] ofs,
                            logic [31:0] ts);
      stats_word_t r;
      int sig;
      r = '{default: 0};
      case (op)
        pdws_pkg::OpSample: begin
          sig = int'(smp) - int'(ofs);
          if (wcnt < 64'hFFFF_FFFF) begin
            wsum += sig;
            wcnt++;
          end
          if (sig < wlow) wlow = sig;
          if (sig > whigh) whigh = sig;
          if (!inp) begin
            if (sig >= trig) begin
              inp = 1; rstart = ts; add_to_run(sig);
            end
          end else begin
            add_to_run(sig);
            if (sig < trig) begin
              if (hlen <= rcnt[31:0]) begin
                lsaved = pcnt - 1; hnum = pcnt; pcnt = pcnt + 1;
                hstart = rstart; hlen = rcnt[31:0]; hpeak = rpeak;
                hmean = rcnt != 0 ? int'(rsum / longint'(rcnt)) : 0;
              end
              rsum = 0; rcnt = 0; rpeak = 0; rstart = 0; inp = 0;
            end
          end
        end
        pdws_pkg::OpReadWindow: begin
          r.wmin = 13'(wlow); r.wmax = 13'(whigh);
          r.wave = wcnt != 0 ? 13'(wsum / longint'(wcnt)) : 13'sd0;
          wsum = 0; wcnt = 0; wlow = 4095; whigh = -4095;
        end
        pdws_pkg::OpReadPulse: begin
          r.pstart = hstart; r.plen = hlen; r.ppeak = 13'(hpeak); r.pmean = 13'(hmean);
          r.pnum = hnum;
          hstart = 0; hlen = 0; hpeak = 0; hmean = 0; hnum = 0;
        end
        default: ;
      endcase
      r.nextnum = pcnt; r.lastnum = lsaved; r.in_pulse = inp;
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch word %0d %s: got %0d expected %0d", words_seen, what, got, want);
      errors++;
    endtask

    task check_word(logic [231:0] d);
      stats_word_t e;
      words_seen++;
      if (pending.size() == 0) begin
        $display("unexpected word %0d", words_seen);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[12:0] !== e.wmin) report("window_min", $signed(d[12:0]), e.wmin);
      if (d[25:13] !== e.wave) report("window_ave", $signed(d[25:13]), e.wave);
      if (d[38:26] !== e.wmax) report("window_max", $signed(d[38:26]), e.wmax);
      if (d[70:39] !== e.pstart) report("pulse_start_time", d[70:39], e.pstart);
      if (d[102:71] !== e.plen) report("pulse_length", d[102:71], e.plen);
      if (d[115:103] !== e.ppeak) report("pulse_peak", $signed(d[115:103]), e.ppeak);
      if (d[128:116] !== e.pmean) report("pulse_mean", $signed(d[128:116]), e.pmean);
      if (d[160:129] !== e.pnum) report("pulse_number", d[160:129], e.pnum);
      if (d[192:161] !== e.nextnum) report("next_pulse_number", d[192:161], e.nextnum);
      if (d[224:193] !== e.lastnum) report("last_saved_number", d[224:193], e.lastnum);
      if (d[225] !== e.in_pulse) report("inside_pulse", d[225], e.in_pulse);
      if (d[231:226] !== 6'b000000) report("zero fill", 1, 0);
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid_i = 0, m_axis_tready_i = 0;
  logic [55:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic s_axis_tready_o, m_axis_tvalid_o;
  logic [231:0] m_axis_tdata_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  pulse_scoreboard board = new();
  bit quiet_tail;
  int idle_cycles, words_sent;

  pulse_detector_with_window_stats_core uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_word(m_axis_tdata_o);
    if (rst_ni && (s_axis_tvalid_i && s_axis_tready_o || m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("pulse_detector_with_window_stats_core_test: done, errors");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 0;
        n = $urandom_range(1, 19);
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready_i <= 1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic write_trigger(logic signed [12:0] level);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= 0; pwdata <= {{19{level[12]}}, level};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.trig = level;
  endtask

  task automatic send_word(pdws_pkg::op_e op, logic [11:0] smp, logic [11:0] ofs,
                           logic [31:0] ts);
    int n;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 19);
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {ts, ofs, smp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_word(op, smp, ofs, ts);
    s_axis_tvalid_i <= 0;
    words_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_level(int sig, logic [31:0] ts);
    logic [11:0] ofs;
    if (sig >= 0) ofs = 12'($urandom_range(0, 4095 - sig));
    else ofs = 12'($urandom_range(-sig, 4095));
    send_word(pdws_pkg::OpSample, 12'(ofs + sig), ofs, ts);
  endtask

  task automatic drain();
    wait (board.pending.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  // a random mix of pulses of random length around the trigger, reads and random opcodes
  task automatic random_phase(int count, int trig);
    int k, len, amp;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: send_word(pdws_pkg::OpReadWindow, 12'($urandom), 12'($urandom), $urandom);
        1: send_word(pdws_pkg::OpReadPulse, 12'($urandom), 12'($urandom), $urandom);
        2: send_word(pdws_pkg::op_e'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
                     $urandom);
        default: begin
          len = $urandom_range(0, 6);
          amp = 4095 - trig;
          repeat (len) send_level(trig + $urandom_range(0, amp < 0 ? 0 : amp), $urandom);
          if (trig > -4095) send_level(trig - 1 - $urandom_range(0, trig + 4094), $urandom);
          k += len;
        end
      endcase
    end
  endtask

  initial begin
    board.clear_all();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    // directed: extremes, every opcode, unused opcode, reads on empty state
    send_word(pdws_pkg::OpReadWindow, 0, 0, 0);
    send_word(pdws_pkg::OpReadPulse, 0, 0, 0);
    send_word(pdws_pkg::OpSample, 12'hFFF, 0, 32'hFFFF_FFFF);
    send_word(pdws_pkg::OpSample, 12'hFFF, 0, 32'h1234);
    send_word(pdws_pkg::OpReadPulse, 0, 0, 0);
    send_word(pdws_pkg::OpSample, 0, 12'hFFF, 32'h5);
    send_word(pdws_pkg::OpUnused, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_word(pdws_pkg::OpReadWindow, 0, 0, 0);
    send_word(pdws_pkg::OpReadPulse, 0, 0, 0);
    send_word(pdws_pkg::OpSample, 12'h800, 12'h7FF, 32'hAAAA_5555);
    send_word(pdws_pkg::OpReadPulse, 0, 0, 0);
    send_word(pdws_pkg::OpSample, 12'h7FF, 12'h800, 32'h5555_AAAA);
    send_word(pdws_pkg::OpReadPulse, 0, 0, 0);
    send_word(pdws_pkg::OpReadWindow, 0, 0, 0);
    drain();

    write_trigger(13'sd4095);
    send_level(4095, 32'h77);
    send_level(4095, 32'h78);
    send_word(pdws_pkg::OpReadPulse, 0, 0, 0);
    send_level(0, 32'h79);
    send_word(pdws_pkg::OpReadPulse, 0, 0, 0);
    drain();
    write_trigger(-13'sd4095);
    random_phase(300, -4095);
    drain();
    write_trigger(13'sd100);
    random_phase(400, 100);
    drain();
    write_trigger(-13'sd300);
    random_phase(300, -300);
    drain();
    write_trigger(13'sd0);
    quiet_tail = 1;
    random_phase(400, 0);
    send_word(pdws_pkg::OpReadWindow, 0, 0, 0);
    send_word(pdws_pkg::OpReadPulse, 0, 0, 0);
    wait (board.pending.size() == 0);
    repeat (100) @(posedge clk_i);

    $display("sent %0d words over five trigger levels, checked %0d results",
             words_sent, board.words_seen);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("pulse_detector_with_window_stats_core_test: done, clean");
    else
      $display("pulse_detector_with_window_stats_core_test: done, errors");
    $finish;
  end
endmodule

>>> sim.f
rtl/core/pdws_pkg.sv
rtl/core/pdws_div.sv
rtl/core/pdws_datapath.sv
rtl/core/pdws_ctrl.sv
rtl/core/pulse_detector_with_window_stats_core.sv
rtl/core/pdws_checker.sv
verif/pulse_detector_with_window_stats_core_test.sv
